// ===== rtl/core/md5_stream_hasher_defines.svh =====
// Assertion macros shared by the MD5 stream hasher RTL.
// Depends on nothing; the asserting modules must have clk and rst_n in scope.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MD5_ASSERT_NOW(lbl, ante, cons, msg)
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/md5_pkg.sv =====
// Shared types, constants and round functions for the MD5 stream hasher.
// Used by md5_ctrl, md5_dpath and md5_stream_hasher; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] TAIL_LIMIT = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST  = 2'd3;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Datapath commands, one set per cycle.
    typedef struct packed {
        logic       write_byte;
        logic       pad;
        logic       clear_all;
        logic       write_len;
        logic       load;
        logic       round;
        logic       add;
        logic       emit_load;
        logic       restart;
        logic [5:0] round_idx;
        logic [5:0] km_idx;
        logic [1:0] word_sel;
    } md5_cmd_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic fill_full;
        logic tail_long;
        logic out_free;
    } md5_status_t;

    // Message word used by round j.
    function automatic logic [3:0] msg_index(input logic [5:0] j);
        logic [3:0] jl;
        logic [3:0] idx;
        jl = j[3:0];
        case (j[5:4])
            2'd0:    idx = jl;
            2'd1:    idx = jl * 4'd5 + 4'd1;
            2'd2:    idx = jl * 4'd3 + 4'd5;
            default: idx = jl * 4'd7;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/md5_ctrl.sv =====
// Sequencer for the MD5 stream hasher: accepts words, runs compressions, emits the digest.
// Depends on md5_pkg and md5_stream_hasher_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_stream_hasher_defines.svh"

module md5_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                kind,
    input  md5_pkg::md5_status_t status,
    output logic                item_stall,
    output md5_pkg::md5_cmd_t   cmd
);
    import md5_pkg::*;

    localparam logic KIND_DATA = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    // What follows the chaining add.
    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,
        MODE_PAD   = 2'd1,
        MODE_FINAL = 2'd2
    } mode_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic [5:0] round_cnt_reg, round_cnt_next;
    logic [1:0] word_cnt_reg, word_cnt_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        round_cnt_next = round_cnt_reg;
        word_cnt_next  = word_cnt_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind == KIND_DATA)
                    begin
                        cmd.write_byte = 1'b1;
                        if (status.fill_full)
                        begin
                            mode_next  = MODE_DATA;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        cmd.pad = 1'b1;
                        if (status.tail_long)
                        begin
                            mode_next = MODE_PAD;
                        end
                        else
                        begin
                            cmd.write_len = 1'b1;
                            mode_next     = MODE_FINAL;
                        end
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load       = 1'b1;
                cmd.km_idx     = '0;
                round_cnt_next = '0;
                state_next     = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round      = 1'b1;
                cmd.round_idx  = round_cnt_reg;
                cmd.km_idx     = round_cnt_reg + 6'd1;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                case (mode_reg)
                    MODE_PAD:
                    begin
                        cmd.clear_all = 1'b1;
                        cmd.write_len = 1'b1;
                        mode_next     = MODE_FINAL;
                        state_next    = S_LOAD;
                    end
                    MODE_FINAL:
                    begin
                        word_cnt_next = '0;
                        state_next    = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.word_sel  = word_cnt_reg;
                    word_cnt_next = word_cnt_reg + 2'd1;
                    if (word_cnt_reg == WORD_LAST)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_DATA;
            round_cnt_reg <= '0;
            word_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            round_cnt_reg <= round_cnt_next;
            word_cnt_reg  <= word_cnt_next;
        end
    end

    `MD5_ASSERT_NOW(a_add_after_last_round, state_reg == S_ADD,
        $past(state_reg == S_ROUND && round_cnt_reg == ROUND_LAST),
        "chaining add without a completed round sweep")
    `MD5_ASSERT_NOW(a_load_source, state_reg == S_LOAD,
        $past(state_reg == S_IDLE || state_reg == S_ADD),
        "block load from an unexpected state")
    `MD5_ASSERT_NEXT(a_emit_done, cmd.emit_load && word_cnt_reg == WORD_LAST,
        state_reg == S_IDLE, "digest run did not end after word D")

endmodule

`default_nettype wire

// ===== rtl/core/md5_dpath.sv =====
// Datapath for the MD5 stream hasher: block store, round unit, chaining words, output register.
// Depends on md5_pkg and md5_stream_hasher_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_stream_hasher_defines.svh"

module md5_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  md5_pkg::md5_cmd_t    cmd,
    input  logic                 result_stall,
    output md5_pkg::md5_status_t status,
    output logic                 result_valid,
    output logic [31:0]          digest_word,
    output logic [1:0]           word_index,
    output logic                 last_word
);
    import md5_pkg::*;

    logic [31:0] blk_reg [16];
    logic [31:0] blk_next [16];
    logic [5:0]  fill_reg;
    logic [60:0] msg_reg;
    logic [31:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] km_reg, km_next;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [1:0]  out_idx_reg;
    logic        out_last_reg;

    logic [3:0]  blk_w;
    logic [1:0]  blk_lane;
    logic [63:0] len_bits;
    logic [1:0]  phase;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [31:0] new_b;
    logic [31:0] chain_sel;

    assign blk_w    = fill_reg[5:2];
    assign blk_lane = fill_reg[1:0];
    assign len_bits = {msg_reg, 3'b000};

    // Block store update: byte insert, padding, clear, length words.
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            blk_next[k] = blk_reg[k];
        end
        if (cmd.write_byte)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (2'(l) == blk_lane)
                begin
                    blk_next[blk_w][8*l +: 8] = data_byte;
                end
                else if (blk_lane == 2'd0)
                begin
                    blk_next[blk_w][8*l +: 8] = 8'h00;
                end
            end
        end
        if (cmd.pad)
        begin
            for (int k = 0; k < 16; k++)
            begin
                if (4'(k) == blk_w)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (2'(l) == blk_lane)
                        begin
                            blk_next[k][8*l +: 8] = PAD_BYTE;
                        end
                        else if (2'(l) > blk_lane)
                        begin
                            blk_next[k][8*l +: 8] = 8'h00;
                        end
                    end
                end
                else if (4'(k) > blk_w)
                begin
                    blk_next[k] = '0;
                end
            end
        end
        if (cmd.clear_all)
        begin
            for (int k = 0; k < 16; k++)
            begin
                blk_next[k] = '0;
            end
        end
        if (cmd.write_len)
        begin
            blk_next[14] = len_bits[31:0];
            blk_next[15] = len_bits[63:32];
        end
    end

    // One round per cycle; K plus message word is fetched a round ahead.
    assign phase   = cmd.round_idx[5:4];
    assign f_val   = round_f(phase, b_reg, c_reg, d_reg);
    assign sum     = a_reg + f_val + km_reg;
    assign new_b   = b_reg + rotl32(sum, ROT_AMT[{phase, cmd.round_idx[1:0]}]);
    assign km_next = ROUND_K[cmd.km_idx] + blk_reg[msg_index(cmd.km_idx)];

    always_comb
    begin
        case (cmd.word_sel)
            2'd0:    chain_sel = chain_a_reg;
            2'd1:    chain_sel = chain_b_reg;
            2'd2:    chain_sel = chain_c_reg;
            default: chain_sel = chain_d_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 16; k++)
        begin
            blk_reg[k] <= blk_next[k];
        end
        if (cmd.load)
        begin
            a_reg  <= chain_a_reg;
            b_reg  <= chain_b_reg;
            c_reg  <= chain_c_reg;
            d_reg  <= chain_d_reg;
            km_reg <= km_next;
        end
        else if (cmd.round)
        begin
            a_reg  <= d_reg;
            d_reg  <= c_reg;
            c_reg  <= b_reg;
            b_reg  <= new_b;
            km_reg <= km_next;
        end
        if (cmd.emit_load)
        begin
            out_word_reg <= chain_sel;
            out_idx_reg  <= cmd.word_sel;
            out_last_reg <= (cmd.word_sel == WORD_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_a_reg   <= IV_A;
            chain_b_reg   <= IV_B;
            chain_c_reg   <= IV_C;
            chain_d_reg   <= IV_D;
            fill_reg      <= '0;
            msg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.add)
            begin
                chain_a_reg <= chain_a_reg + a_reg;
                chain_b_reg <= chain_b_reg + b_reg;
                chain_c_reg <= chain_c_reg + c_reg;
                chain_d_reg <= chain_d_reg + d_reg;
            end
            else if (cmd.restart)
            begin
                chain_a_reg <= IV_A;
                chain_b_reg <= IV_B;
                chain_c_reg <= IV_C;
                chain_d_reg <= IV_D;
            end
            if (cmd.restart)
            begin
                fill_reg <= '0;
                msg_reg  <= '0;
            end
            else if (cmd.write_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
                msg_reg  <= msg_reg + 61'd1;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.fill_full = (fill_reg == FILL_LAST);
    assign status.tail_long = (fill_reg >= TAIL_LIMIT);
    assign status.out_free  = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign digest_word  = out_word_reg;
    assign word_index   = out_idx_reg;
    assign last_word    = out_last_reg;

    `MD5_ASSERT_NOW(a_last_is_d, out_valid_reg && out_last_reg, out_idx_reg == WORD_LAST,
        "last flag on a word other than D")

endmodule

`default_nettype wire

// ===== rtl/core/md5_stream_hasher.sv =====
// MD5 stream hasher: RFC 1321 digest over a byte stream, one byte per accepted word.
// Top level; depends on md5_pkg, md5_ctrl and md5_dpath.
`timescale 1ns / 1ps
`default_nettype none

// A data word (kind 0) adds one message byte and is taken whenever the hasher
// is idle. Every 64th byte fills the block and starts a compression: a load
// step, 64 rounds through the single round unit and a chaining add, during
// which the input stalls. An end word (kind 1) pads the block and compresses
// once, or twice when 56 or more bytes of the last block were in use; the
// four digest words A, B, C, D then leave through the output register, one
// per cycle while result_stall is low, and last_word marks D. The hasher
// takes the next input word as soon as D sits in the output register; the
// chaining words, byte count and block fill are back at their initial values
// by then. For long messages, throughput is set by the one-round-per-cycle
// compression loop, as no bytes are taken while a compression runs.

module md5_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t status;

    // Sequencer: owns the handshake on the input side and the round count.
    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (kind),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // Datapath: block store, round unit, chaining words and output register.
    md5_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

endmodule

`default_nettype wire
